>>> rtl/core/pbde_pkg.sv
// ----------------------------------------------------------------------------
// pbde_pkg
// Shared types and constants for the parallel bit deposit/extract unit.
// ----------------------------------------------------------------------------
package pbde_pkg;

	localparam int DATA_W    = 64;
	localparam int LANE_W    = 8;
	localparam int NUM_CELLS = DATA_W / LANE_W;
	localparam int CNT_W     = $clog2(DATA_W + 1);
	localparam int SHAMT_W   = $clog2(LANE_W + 1);
	localparam int HALF_W    = DATA_W / 2;

	// operation codes carried in tuser
	typedef enum logic {
		FUNC_DEPOSIT = 1'b0,
		FUNC_EXTRACT = 1'b1
	} func_t;

	// work item handed from cell to cell
	typedef struct packed {
		func_t               func;
		logic [DATA_W-1:0]   value;   // remaining source bits, low end is next
		logic [DATA_W-1:0]   mask;    // remaining mask bits, low byte is next
		logic [DATA_W-1:0]   result;  // partial result
		logic [CNT_W-1:0]    cnt;     // extract: bits packed so far
	} item_t;

endpackage

>>> rtl/core/pbde_cell.sv
// ----------------------------------------------------------------------------
// pbde_cell
// One cell of the chain: handles the low mask byte of the item, then shifts
// value, mask and, for deposit, result along. Holds one stage register.
// ----------------------------------------------------------------------------
module pbde_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            up_valid,
	output logic            up_ready,
	input  pbde_pkg::item_t up_item,
	output logic            dn_valid,
	input  logic            dn_ready,
	output pbde_pkg::item_t dn_item
);

	localparam int LW = pbde_pkg::LANE_W;

	// gather the bits of src selected by m into the low end
	function automatic logic [LW-1:0] compress_lane(input logic [LW-1:0] src,
							input logic [LW-1:0] m);
		logic [LW-1:0]               r;
		logic [pbde_pkg::SHAMT_W-1:0] j;
		r = '0;
		j = '0;
		for (int i = 0; i < LW; i++) begin
			if (m[i]) begin
				r[j[$clog2(LW)-1:0]] = src[i];
				j = j + 1'b1;
			end
		end
		return r;
	endfunction

	// scatter the low bits of src to the set positions of m
	function automatic logic [LW-1:0] expand_lane(input logic [LW-1:0] src,
						      input logic [LW-1:0] m);
		logic [LW-1:0]               r;
		logic [pbde_pkg::SHAMT_W-1:0] j;
		r = '0;
		j = '0;
		for (int i = 0; i < LW; i++) begin
			if (m[i]) begin
				r[i] = src[j[$clog2(LW)-1:0]];
				j = j + 1'b1;
			end
		end
		return r;
	endfunction

	logic                         valid_q;
	pbde_pkg::item_t              item_q;
	pbde_pkg::item_t              nxt;
	logic [LW-1:0]                lane_m;
	logic [LW-1:0]                lane_v;
	logic [pbde_pkg::SHAMT_W-1:0] pop;
	logic [pbde_pkg::SHAMT_W-1:0] vshift;

	assign up_ready = !valid_q || dn_ready;

	always_comb begin
		lane_m = up_item.mask[LW-1:0];
		lane_v = up_item.value[LW-1:0];
		pop    = '0;
		for (int i = 0; i < LW; i++) begin
			pop = pop + pbde_pkg::SHAMT_W'(lane_m[i]);
		end
		// deposit consumes as many source bits as the lane has mask bits
		vshift = (up_item.func == pbde_pkg::FUNC_EXTRACT) ?
			 pbde_pkg::SHAMT_W'(LW) : pop;

		nxt       = up_item;
		nxt.value = up_item.value >> vshift;
		nxt.mask  = up_item.mask >> LW;
		nxt.cnt   = up_item.cnt + pbde_pkg::CNT_W'(pop);
		unique case (up_item.func)
			pbde_pkg::FUNC_DEPOSIT: begin
				nxt.result = {expand_lane(lane_v, lane_m),
					      up_item.result[pbde_pkg::DATA_W-1:LW]};
			end
			pbde_pkg::FUNC_EXTRACT: begin
				nxt.result = up_item.result |
					(pbde_pkg::DATA_W'(compress_lane(lane_v, lane_m))
					 << up_item.cnt);
			end
			default: begin
				nxt.result = up_item.result;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			item_q <= nxt;
		end
	end

	assign dn_valid = valid_q;
	assign dn_item  = item_q;

endmodule

>>> rtl/core/parallel_bit_deposit_extract_top.sv
// ----------------------------------------------------------------------------
// parallel_bit_deposit_extract_top
// Parallel bit deposit (scatter) and extract (gather) at 32 or 64 bits.
// ----------------------------------------------------------------------------
// Usage:
//  - Input stream s_axis_*: one transfer is one operation. tuser selects the
//    operation (bit 0: 0 deposit, 1 extract) and width (bit 1: 0 = 32-bit,
//    1 = 64-bit); tdata carries value (low 64 bits) and mask (high 64 bits).
//  - Output stream m_axis_*: one transfer per operation, in order, holding
//    the 64-bit result; 32-bit operations return bits 63..32 as zero.
//  - Datapath is a chain of eight identical cells, one per mask byte, each
//    with its own stage register. One operation can enter every cycle
//    unless a stalled receiver has backed the chain up.
//  - Each stage advances when it is empty or its successor advances, so
//    bubbles close up and a stalled receiver only backs up the chain once
//    every cell holds an operation.
//  - Reset (arst_n low) empties every stage; no state survives between
//    operations.
// ----------------------------------------------------------------------------
module parallel_bit_deposit_extract_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,  // [63:0] value, [127:64] mask
	input  logic [1:0]   s_axis_tuser,  // [0] func, [1] wide
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [63:0]  m_axis_tdata   // [63:0] result
);

	localparam int N  = pbde_pkg::NUM_CELLS;
	localparam int DW = pbde_pkg::DATA_W;
	localparam int HW = pbde_pkg::HALF_W;

	logic                      wide;
	logic [DW-1:0]             lane_sel;
	pbde_pkg::item_t           entry;

	logic            link_valid [N+1];
	logic            link_ready [N+1];
	pbde_pkg::item_t link_item  [N+1];

	// 32-bit mode: drop upper operand bits up front; the chain then leaves
	// the upper result bits at zero on its own.
	always_comb begin
		wide         = s_axis_tuser[1];
		lane_sel     = wide ? {DW{1'b1}} : {{HW{1'b0}}, {HW{1'b1}}};
		entry.func   = pbde_pkg::func_t'(s_axis_tuser[0]);
		entry.value  = s_axis_tdata[DW-1:0] & lane_sel;
		entry.mask   = s_axis_tdata[2*DW-1:DW] & lane_sel;
		entry.result = '0;
		entry.cnt    = '0;
	end

	assign link_valid[0] = s_axis_tvalid;
	assign link_item[0]  = entry;
	assign s_axis_tready = link_ready[0];

	for (genvar g = 0; g < N; g++) begin : g_cell
		pbde_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (link_valid[g]),
			.up_ready (link_ready[g]),
			.up_item  (link_item[g]),
			.dn_valid (link_valid[g+1]),
			.dn_ready (link_ready[g+1]),
			.dn_item  (link_item[g+1])
		);
	end

	// last cell's stage register doubles as the output register
	assign m_axis_tvalid = link_valid[N];
	assign link_ready[N] = m_axis_tready;
	assign m_axis_tdata  = link_item[N].result;

endmodule

>>> tb/sv/pbde_result_checker.sv
// ----------------------------------------------------------------------------
// pbde_result_checker
// Watches both streams of the bit deposit/extract unit. It works out the
// result of every accepted operation, keeps the results in arrival order and
// compares each output transfer with the oldest one still waiting.
// ----------------------------------------------------------------------------
module pbde_result_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,  // [63:0] value, [127:64] mask
	input  logic [1:0]   s_axis_tuser,  // [0] func, [1] wide
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [63:0]  m_axis_tdata,  // [63:0] result
	output int unsigned  fail_count,
	output int unsigned  pending_results
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DW = pbde_pkg::DATA_W;
	localparam int HW = pbde_pkg::HALF_W;

	localparam int unsigned MAX_PRINTED = 100;

	logic [DW-1:0] expected_results[$];
	int unsigned   error_total = 0;

	assign fail_count = error_total;
	initial pending_results = 0;

	// bit-serial scatter/gather, lower half only when wide is low
	function automatic logic [DW-1:0] scatter_gather(pbde_pkg::func_t op, logic wide,
			logic [DW-1:0] value, logic [DW-1:0] mask);
		logic [DW-1:0] src;
		logic [DW-1:0] sel;
		logic [DW-1:0] acc;
		int            k;
		src = wide ? value : {{HW{1'b0}}, value[HW-1:0]};
		sel = wide ? mask : {{HW{1'b0}}, mask[HW-1:0]};
		acc = '0;
		k = 0;
		for (int pos = 0; pos < DW; pos++) begin
			if (sel[pos]) begin
				if (op == pbde_pkg::FUNC_EXTRACT)
					acc[k] = src[pos];
				else
					acc[pos] = src[k];
				k++;
			end
		end
		if (!wide)
			acc[DW-1:HW] = '0;
		return acc;
	endfunction

	task automatic report_mismatch(string msg);
		if (error_total < MAX_PRINTED)
			$display("ERROR %0t ns: %s", $time, msg);
		error_total++;
	endtask

	always @(posedge clk) begin
		logic [DW-1:0] want;
		if (arst_n) begin
			// outputs first: every result comes out of a stage register, so a result
			// never belongs to an operation taken at the same edge
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("result %h with nothing outstanding",
						m_axis_tdata));
				end else begin
					want = expected_results.pop_front();
					if (m_axis_tdata !== want)
						report_mismatch($sformatf("result %h, expected %h",
							m_axis_tdata, want));
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				expected_results.push_back(scatter_gather(
					pbde_pkg::func_t'(s_axis_tuser[0]),
					s_axis_tuser[1], s_axis_tdata[DW-1:0],
					s_axis_tdata[2*DW-1:DW]));
		end
		pending_results <= expected_results.size();
	end

endmodule

>>> tb/sv/parallel_bit_deposit_extract_top_tb.sv
// ----------------------------------------------------------------------------
// parallel_bit_deposit_extract_top_tb
// Stimulus and verdict for the bit deposit/extract unit. A directed set hits
// empty, full, single and two-bit masks and junk in the upper half of 32-bit
// operations; random operations follow in three flow-control phases. Results
// are checked by pbde_result_checker.
// ----------------------------------------------------------------------------
module parallel_bit_deposit_extract_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned OPS_PER_PHASE = 630;
	localparam int unsigned DRAIN_CYCLES  = 20;      // pipeline is 8 deep
	localparam int unsigned CYCLE_LIMIT   = 400000;  // far above the slowest pass

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [127:0] s_axis_tdata = '0;   // [63:0] value, [127:64] mask
	logic [1:0]   s_axis_tuser = '0;   // [0] func, [1] wide
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [63:0]  m_axis_tdata;        // [63:0] result

	int unsigned  fail_count;
	int unsigned  pending_results;
	int unsigned  cycle_count = 0;

	// chance in percent that a given cycle is idle on each side
	int unsigned  src_idle_pct = 7;
	int unsigned  snk_idle_pct = 87;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	parallel_bit_deposit_extract_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	pbde_result_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_axis_tvalid   (s_axis_tvalid),
		.s_axis_tready   (s_axis_tready),
		.s_axis_tdata    (s_axis_tdata),
		.s_axis_tuser    (s_axis_tuser),
		.m_axis_tvalid   (m_axis_tvalid),
		.m_axis_tready   (m_axis_tready),
		.m_axis_tdata    (m_axis_tdata),
		.fail_count      (fail_count),
		.pending_results (pending_results)
	);

	// receiver backpressure, redrawn every cycle
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
	end

	// watchdog: a hung pipeline or a lost result ends up here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// one operation per transfer; random gaps in front, then hold until taken
	task automatic send_op(pbde_pkg::func_t op, logic wide, logic [63:0] value,
			logic [63:0] mask);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {mask, value};
		s_axis_tuser  <= {wide, op};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	function automatic logic [63:0] pick_value();
		case ($urandom_range(7))
			0:       return '0;
			1:       return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// mask shapes with varied counts and placements of set bits
	function automatic logic [63:0] pick_mask();
		logic [63:0] m;
		int unsigned lo;
		int unsigned hi;
		case ($urandom_range(5))
			0: m = {$urandom, $urandom};
			1: begin
				// sparse: zero to three set bits
				m = '0;
				repeat ($urandom_range(3)) m[$urandom_range(63)] = 1'b1;
			end
			2: begin
				// dense: a few holes in an all-ones mask
				m = '1;
				repeat ($urandom_range(1, 3)) m[$urandom_range(63)] = 1'b0;
			end
			3: begin
				// one contiguous field
				lo = $urandom_range(63);
				hi = $urandom_range(63, lo);
				m = '0;
				for (int b = lo; b <= hi; b++)
					m[b] = 1'b1;
			end
			4: m = {$urandom, $urandom} & {$urandom, $urandom};
			default: m = {$urandom, $urandom} | {$urandom, $urandom};
		endcase
		return m;
	endfunction

	task automatic send_random_ops(int unsigned count);
		repeat (count)
			send_op(pbde_pkg::func_t'($urandom_range(1)), 1'($urandom_range(1)),
				pick_value(), pick_mask());
	endtask

	initial begin
		pbde_pkg::func_t op;
		logic            wide;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners, both operations at both widths
		for (int f = 0; f < 2; f++) begin
			for (int w = 0; w < 2; w++) begin
				op   = pbde_pkg::func_t'(f);
				wide = 1'(w);
				send_op(op, wide, '1, '0);                          // empty mask
				send_op(op, wide, '1, '1);                          // full mask
				send_op(op, wide, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
				send_op(op, wide, '1, wide ? 64'h8000_0000_0000_0000
				                           : 64'h0000_0000_8000_0000); // top bit only
			end
		end
		// lowest bit alone, and a two-bit mask spanning the whole word
		send_op(pbde_pkg::FUNC_DEPOSIT, 1'b1, 64'h1, 64'h1);
		send_op(pbde_pkg::FUNC_EXTRACT, 1'b1, 64'h8000_0000_0000_0001,
			64'h8000_0000_0000_0001);
		send_op(pbde_pkg::FUNC_DEPOSIT, 1'b1, 64'h3, 64'h8000_0000_0000_0001);
		// 32-bit operations with junk in the upper halves, which must not leak
		send_op(pbde_pkg::FUNC_DEPOSIT, 1'b0, 64'hFFFF_FFFF_0000_00FF,
			64'hFFFF_FFFF_0F0F_0F0F);
		send_op(pbde_pkg::FUNC_EXTRACT, 1'b0, 64'hFFFF_FFFF_F0F0_F0F0,
			64'hFFFF_FFFF_FFFF_0000);
		send_op(pbde_pkg::FUNC_EXTRACT, 1'b0, 64'hDEAD_BEEF_0000_0000,
			64'hFFFF_FFFF_0000_0000);

		// phase 1: sender mostly busy, receiver mostly stalled
		send_random_ops(OPS_PER_PHASE);

		// phase 2: the other way round
		src_idle_pct = 87;
		snk_idle_pct = 7;
		send_random_ops(OPS_PER_PHASE);

		// phase 3: full rate both sides
		src_idle_pct = 0;
		snk_idle_pct = 0;
		send_random_ops(OPS_PER_PHASE);
		s_axis_tvalid <= 1'b0;

		// drain, then keep clocking to catch stray output transfers
		while (pending_results != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

>>> sim.f
rtl/core/pbde_pkg.sv
rtl/core/pbde_cell.sv
rtl/core/parallel_bit_deposit_extract_top.sv
tb/sv/pbde_result_checker.sv
tb/sv/parallel_bit_deposit_extract_top_tb.sv
